/* rtl/etf_pkg.sv */
// Shared constants, register codes and the log2 table of the escape-time pixel unit.
`timescale 1ns / 1ps

package etf_pkg;

    // Fixed formats of the coordinate and resolution registers, and widths of the result fields and the register index.
    localparam int COORD_BITS = 32;
    localparam int FRAME_BITS = 13;
    localparam int FRAC_BITS  = 28;
    localparam int ITER_OUT_BITS = 10;
    localparam int COLOR_BITS = 8;
    localparam int CFG_INDEX_BITS = 3;

    // Escape bound |z|^2 > 4.0 in Q.28.
    localparam logic [36:0] ESCAPE_LIMIT = 37'(64'd4 << FRAC_BITS);

    // ceil(2^32 / 10): exact division by ten for dividends below 2^30.
    localparam logic [31:0] RECIP_TEN = 32'd429496730;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_X_RIGHT  = 3'd0,
        REG_X_LEFT   = 3'd1,
        REG_Y_TOP    = 3'd2,
        REG_Y_BOTTOM = 3'd3,
        REG_WIDTH    = 3'd4,
        REG_HEIGHT   = 3'd5
    } cfg_index_t;

    // round(65536 * log2(1 + k/16)) for k = 0 .. 16.
    function automatic logic [16:0] log_entry(input logic [4:0] k);
        logic [16:0] v;
        case (k)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd5732;
            5'd2:    v = 17'd11136;
            5'd3:    v = 17'd16248;
            5'd4:    v = 17'd21098;
            5'd5:    v = 17'd25711;
            5'd6:    v = 17'd30109;
            5'd7:    v = 17'd34312;
            5'd8:    v = 17'd38336;
            5'd9:    v = 17'd42196;
            5'd10:   v = 17'd45904;
            5'd11:   v = 17'd49472;
            5'd12:   v = 17'd52911;
            5'd13:   v = 17'd56229;
            5'd14:   v = 17'd59434;
            5'd15:   v = 17'd62534;
            5'd16:   v = 17'd65536;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/escape_time_fractal_pixel.sv */
// Escape-time fractal pixel unit: maps a pixel, iterates z = z*z + c and colors the result.
`timescale 1ns / 1ps
//
// Usage: write the plane window and the resolution through the cfg port while the
// unit is idle (cfg_ready is always high). Send one pixel word on the s_ channel,
// column in the low bits and row above it. One result word leaves on the m_ channel
// holding the echoed position, the escape flag, the iteration count and the color.
// Each pixel is mapped to the plane, then iterated; an escaping pixel then goes through
// the log and color steps, while a black one goes straight to the output.
// All products go through one 32x32 multiplier register: each iteration needs
// three products (x*x, y*y, x*y) and an update step, and the mapping uses a
// one-bit-per-cycle divider per axis. One pixel is in work at a time; s_tready is
// high only while the sequencer is idle, so a pixel can be taken in the cycle after the
// previous word is handed over. A finished word sits in the output register until
// the receiver takes it, and the next pixel may be accepted meanwhile; a new result
// waits in its last state if the register is still full.
// Reset (aresetn low, synchronous) returns the window and resolution to their defaults,
// empties the output register and idles the sequencer.
//
module escape_time_fractal_pixel import etf_pkg::*; #(
    parameter int MAX_ITERATIONS = 1000,
    parameter int POSITION_BITS  = 12
) (
    input  logic aclk,
    input  logic aresetn,
    // Configuration writes.
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]     cfg_data,
    // Pixel words; tdata: pixel_column, pixel_row, zero fill.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((2*POSITION_BITS+7)/8)*8-1:0] s_tdata,
    // Result words; tdata: out_column, out_row, escaped, iteration_count,
    // red, green, blue, zero fill.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((2*POSITION_BITS+42)/8)*8-1:0] m_tdata
);

    localparam int PB       = POSITION_BITS;
    localparam int OUT_USED = 2*PB + 1 + ITER_OUT_BITS + 3*COLOR_BITS;
    localparam int OUT_BITS = ((2*PB+42)/8)*8;
    localparam int IW       = $clog2(MAX_ITERATIONS+1);
    localparam int PW       = ((PB > FRAME_BITS) ? PB : FRAME_BITS) + 1;
    localparam int NUM_BITS = COORD_BITS + PW;
    localparam int CW       = $clog2(NUM_BITS+1);
    localparam int SUM_BITS = NUM_BITS + 2;
    localparam int SW       = IW + 18;

    localparam logic signed [SUM_BITS-1:0] SAT_HI = SUM_BITS'(2147483647);
    localparam logic signed [SUM_BITS-1:0] SAT_LO = ~SAT_HI;
    localparam logic [IW-1:0] ITER_LIMIT = IW'(MAX_ITERATIONS);

    typedef enum logic [4:0] {
        ST_IDLE, ST_MAP_MUL, ST_MAP_LOAD, ST_MAP_DIV, ST_MAP_ADD,
        ST_IT_XX, ST_IT_YY, ST_IT_XY, ST_IT_UPD,
        ST_LOG_NORM, ST_LOG_MUL, ST_LOG_ADD, ST_SMOOTH,
        ST_COL_DIV, ST_COL_SET, ST_BL_MUL, ST_BL_ACC, ST_OUT
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic signed [COORD_BITS-1:0] x_right_reg, x_left_reg, y_top_reg, y_bottom_reg;
    logic [FRAME_BITS-1:0] width_reg, height_reg;

    // Pixel and mapping registers.
    logic [PB-1:0] col_reg, row_reg;
    logic axis_reg, neg_reg;
    logic [NUM_BITS-1:0] num_reg;
    logic [FRAME_BITS-1:0] rem_reg;
    logic [CW-1:0] cnt_reg;
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg;

    // Iteration registers.
    logic signed [33:0] x_reg, y_reg;
    logic [35:0] xx_reg, yy_reg;
    logic [IW-1:0] iter_reg;
    logic esc_reg;

    // Log and color registers.
    logic [39:0] norm_reg;
    logic [5:0] exp_reg;
    logic pass_reg;
    logic [IW:0] n_reg;
    logic [15:0] t_reg;
    logic [1:0] ch_reg;
    logic bneg_reg;
    logic [COLOR_BITS-1:0] red_reg, green_reg, blue_reg;
    logic [COLOR_BITS-1:0] p3_reg, p5_reg, p75_reg;

    // Shared multiplier and output register.
    logic [63:0] prod_reg;
    logic [31:0] mul_a, mul_b;
    logic m_valid_reg;
    logic [OUT_BITS-1:0] m_data_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Mapping operands for the current axis.
    logic [FRAME_BITS-1:0] w_eff, h_eff, span;
    logic signed [COORD_BITS-1:0] map_start, map_end;
    logic signed [32:0] map_d;
    logic [31:0] d_mag;
    logic signed [PW-1:0] map_pos, pos_mag;

    assign w_eff = (width_reg == '0) ? FRAME_BITS'(1) : width_reg;
    assign h_eff = (height_reg == '0) ? FRAME_BITS'(1) : height_reg;
    assign span  = axis_reg ? h_eff : w_eff;
    assign map_start = axis_reg ? y_bottom_reg : x_left_reg;
    assign map_end   = axis_reg ? y_top_reg : x_right_reg;
    assign map_d = {map_end[COORD_BITS-1], map_end} - {map_start[COORD_BITS-1], map_start};
    assign d_mag = map_d[32] ? 32'(-map_d) : map_d[31:0];
    assign map_pos = axis_reg ?
        ($signed({{(PW-FRAME_BITS){1'b0}}, h_eff}) - $signed({{(PW-PB){1'b0}}, row_reg})) :
        $signed({{(PW-PB){1'b0}}, col_reg});
    assign pos_mag = map_pos[PW-1] ? -map_pos : map_pos;

    // One restoring divide step.
    logic [FRAME_BITS:0] rem_sh, rem_sub;
    logic div_ge;
    assign rem_sh  = {rem_reg, num_reg[NUM_BITS-1]};
    assign div_ge  = (rem_sh >= {1'b0, span});
    assign rem_sub = rem_sh - {1'b0, span};

    // Signed quotient added to the interval start, saturated to Q4.28.
    logic [NUM_BITS:0] q_ext;
    logic signed [SUM_BITS-1:0] map_sum, map_sat;
    assign q_ext   = neg_reg ? -{1'b0, num_reg} : {1'b0, num_reg};
    assign map_sum = SUM_BITS'(map_start) + $signed({q_ext[NUM_BITS], q_ext});
    assign map_sat = (map_sum > SAT_HI) ? SAT_HI : ((map_sum < SAT_LO) ? SAT_LO : map_sum);

    // Iteration arithmetic.
    logic [31:0] ax, ay;
    logic [36:0] m_sum;
    logic signed [33:0] pxy, txy;
    logic signed [37:0] x_new, y_new;
    assign ax = x_reg[33] ? 32'(-x_reg) : x_reg[31:0];
    assign ay = y_reg[33] ? 32'(-y_reg) : y_reg[31:0];
    assign m_sum = {1'b0, xx_reg} + {1'b0, prod_reg[63:28]};
    assign pxy = $signed({1'b0, prod_reg[59:27]});
    assign txy = (x_reg[33] != y_reg[33]) ? -pxy : pxy;
    assign x_new = $signed({2'b00, xx_reg}) - $signed({2'b00, yy_reg})
                 + {{6{cx_reg[COORD_BITS-1]}}, cx_reg};
    assign y_new = {{4{txy[33]}}, txy} + {{6{cy_reg[COORD_BITS-1]}}, cy_reg};

    // Table interpolation for the log2 unit.
    logic [4:0] lk;
    logic [16:0] lt0, lt1, ldiff, lfrac;
    logic signed [7:0] lexp;
    logic signed [23:0] lval;
    assign lk    = {1'b0, norm_reg[38:35]};
    assign lt0   = log_entry(lk);
    assign lt1   = log_entry(lk + 5'd1);
    assign ldiff = lt1 - lt0;
    assign lfrac = lt0 + {4'd0, prod_reg[24:12]};
    assign lexp  = $signed({2'b00, exp_reg}) - (pass_reg ? 8'sd16 : 8'sd28);
    assign lval  = $signed({lexp, 16'd0}) + $signed({7'd0, lfrac});

    // Smoothed count.
    logic [31:0] iter_ext;
    logic signed [SW-1:0] s_val, s_cl;
    logic [IW+2:0] n3;
    logic [31:0] n_ext, n3_ext;
    assign iter_ext = 32'(iter_reg);
    assign s_val = $signed({2'b00, iter_reg + IW'(0), 16'd0})
                 + $signed(SW'(32'd2 << 16)) - $signed(SW'(norm_reg[39:19]));
    assign s_cl  = s_val[SW-1] ? '0 : s_val;
    assign n3    = {n_reg, 1'b0} + (IW+3)'(n_reg);
    assign n_ext  = 32'(n_reg);
    assign n3_ext = 32'(n3);

    // Blend operands for the current channel.
    logic [COLOR_BITS-1:0] bl_a, bl_b, bl_res;
    logic signed [COLOR_BITS:0] bl_d;
    logic [COLOR_BITS-1:0] bl_mag;
    logic [24:0] bl_rnd;
    always_comb begin
        case (ch_reg)
            2'd0: begin
                bl_a = p3_reg;
                bl_b = p75_reg + 8'd1;
            end
            2'd1: begin
                bl_a = p5_reg;
                bl_b = p3_reg + 8'd1;
            end
            default: begin
                bl_a = p75_reg;
                bl_b = p5_reg + 8'd1;
            end
        endcase
    end
    assign bl_d   = $signed({1'b0, bl_b}) - $signed({1'b0, bl_a});
    assign bl_mag = bl_d[COLOR_BITS] ? COLOR_BITS'(-bl_d) : bl_d[COLOR_BITS-1:0];
    assign bl_rnd = {1'b0, prod_reg[23:0]} + 25'd65535;
    assign bl_res = bneg_reg ? (bl_a - bl_rnd[23:16]) : (bl_a + prod_reg[23:16]);

    // Operand select of the shared multiplier.
    always_comb begin
        case (state_reg)
            ST_MAP_MUL: begin
                mul_a = d_mag;
                mul_b = 32'(pos_mag);
            end
            ST_IT_XX: begin
                mul_a = ax;
                mul_b = ax;
            end
            ST_IT_YY: begin
                mul_a = ay;
                mul_b = ay;
            end
            ST_IT_XY: begin
                mul_a = ax;
                mul_b = ay;
            end
            ST_LOG_MUL: begin
                mul_a = 32'(ldiff);
                mul_b = 32'(norm_reg[34:23]);
            end
            ST_COL_DIV: begin
                mul_a = n3_ext;
                mul_b = RECIP_TEN;
            end
            ST_BL_MUL: begin
                mul_a = 32'(bl_mag);
                mul_b = 32'(t_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Result word layout.
    logic [OUT_USED-1:0] out_word;
    assign out_word = {blue_reg, green_reg, red_reg, iter_ext[ITER_OUT_BITS-1:0],
                       esc_reg, row_reg, col_reg};

    // Sequencer, configuration and output register.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            x_right_reg  <= 32'sd268435456;
            x_left_reg   <= -32'sd536870912;
            y_top_reg    <= 32'sd268435456;
            y_bottom_reg <= -32'sd268435456;
            width_reg    <= FRAME_BITS'(800);
            height_reg   <= FRAME_BITS'(600);
        end else begin
            // Configuration write; unknown indexes are dropped.
            if (cfg_valid) begin
                case (cfg_index)
                    REG_X_RIGHT:  x_right_reg  <= cfg_data;
                    REG_X_LEFT:   x_left_reg   <= cfg_data;
                    REG_Y_TOP:    y_top_reg    <= cfg_data;
                    REG_Y_BOTTOM: y_bottom_reg <= cfg_data;
                    REG_WIDTH:    width_reg    <= cfg_data[FRAME_BITS-1:0];
                    REG_HEIGHT:   height_reg   <= cfg_data[FRAME_BITS-1:0];
                    default: ;
                endcase
            end

            // The output register empties when taken, unless a new word refills it.
            if (m_valid_reg && m_tready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        col_reg   <= s_tdata[PB-1:0];
                        row_reg   <= s_tdata[2*PB-1:PB];
                        axis_reg  <= 1'b0;
                        state_reg <= ST_MAP_MUL;
                    end
                end
                // |d| * |pos| goes into the multiplier register.
                ST_MAP_MUL: begin
                    neg_reg   <= map_d[32] ^ map_pos[PW-1];
                    state_reg <= ST_MAP_LOAD;
                end
                ST_MAP_LOAD: begin
                    num_reg   <= prod_reg[NUM_BITS-1:0];
                    rem_reg   <= '0;
                    cnt_reg   <= CW'(NUM_BITS);
                    state_reg <= ST_MAP_DIV;
                end
                // One quotient bit per cycle.
                ST_MAP_DIV: begin
                    num_reg <= {num_reg[NUM_BITS-2:0], div_ge};
                    rem_reg <= div_ge ? rem_sub[FRAME_BITS-1:0] : rem_sh[FRAME_BITS-1:0];
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        state_reg <= ST_MAP_ADD;
                    end
                end
                ST_MAP_ADD: begin
                    if (!axis_reg) begin
                        cx_reg    <= map_sat[COORD_BITS-1:0];
                        axis_reg  <= 1'b1;
                        state_reg <= ST_MAP_MUL;
                    end else begin
                        cy_reg    <= map_sat[COORD_BITS-1:0];
                        x_reg     <= '0;
                        y_reg     <= '0;
                        iter_reg  <= '0;
                        state_reg <= ST_IT_XX;
                    end
                end
                ST_IT_XX: begin
                    state_reg <= ST_IT_YY;
                end
                ST_IT_YY: begin
                    xx_reg    <= prod_reg[63:28];
                    state_reg <= ST_IT_XY;
                end
                // Escape test on xx + yy, with x*y issued in parallel.
                ST_IT_XY: begin
                    yy_reg <= prod_reg[63:28];
                    if (m_sum > ESCAPE_LIMIT || iter_reg >= ITER_LIMIT) begin
                        esc_reg   <= (iter_reg < ITER_LIMIT);
                        norm_reg  <= 40'(m_sum);
                        exp_reg   <= 6'd39;
                        pass_reg  <= 1'b0;
                        red_reg   <= '0;
                        green_reg <= '0;
                        blue_reg  <= '0;
                        state_reg <= (iter_reg < ITER_LIMIT) ? ST_LOG_NORM : ST_OUT;
                    end else begin
                        state_reg <= ST_IT_UPD;
                    end
                end
                ST_IT_UPD: begin
                    x_reg     <= x_new[33:0];
                    y_reg     <= y_new[33:0];
                    iter_reg  <= iter_reg + IW'(1);
                    state_reg <= ST_IT_XX;
                end
                // Shift until the leading one reaches the top bit.
                ST_LOG_NORM: begin
                    if (norm_reg[39]) begin
                        state_reg <= ST_LOG_MUL;
                    end else begin
                        norm_reg <= {norm_reg[38:0], 1'b0};
                        exp_reg  <= exp_reg - 6'd1;
                    end
                end
                ST_LOG_MUL: begin
                    state_reg <= ST_LOG_ADD;
                end
                // First pass gives log2(m); the second takes log2 of that.
                ST_LOG_ADD: begin
                    if (!pass_reg) begin
                        norm_reg  <= lval[23] ? '0 : 40'(lval[22:0]);
                        exp_reg   <= 6'd39;
                        pass_reg  <= 1'b1;
                        state_reg <= ST_LOG_NORM;
                    end else begin
                        norm_reg  <= {lval[20:0], 19'd0};
                        state_reg <= ST_SMOOTH;
                    end
                end
                ST_SMOOTH: begin
                    n_reg     <= s_cl[IW+16:16];
                    t_reg     <= s_cl[15:0];
                    state_reg <= ST_COL_DIV;
                end
                ST_COL_DIV: begin
                    state_reg <= ST_COL_SET;
                end
                // Palette indexes 3N/10, N/2 and 3N/4, low byte only.
                ST_COL_SET: begin
                    p3_reg    <= prod_reg[39:32];
                    p5_reg    <= n_ext[8:1];
                    p75_reg   <= n3_ext[9:2];
                    ch_reg    <= 2'd0;
                    state_reg <= ST_BL_MUL;
                end
                ST_BL_MUL: begin
                    bneg_reg  <= bl_d[COLOR_BITS];
                    state_reg <= ST_BL_ACC;
                end
                ST_BL_ACC: begin
                    case (ch_reg)
                        2'd0:    red_reg   <= bl_res;
                        2'd1:    green_reg <= bl_res;
                        default: blue_reg  <= bl_res;
                    endcase
                    ch_reg    <= ch_reg + 2'd1;
                    state_reg <= (ch_reg == 2'd2) ? ST_OUT : ST_BL_MUL;
                end
                // Hand the word over once the output register is free.
                ST_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_data_reg  <= OUT_BITS'(out_word);
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the escape-time fractal pixel unit.
`timescale 1ns / 1ps

module tb_top import etf_pkg::*; ();

    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;
    localparam int ITER_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 570;

    // Result word, highest field first so that the column lands in the low bits.
    typedef struct packed {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [9:0]  iters;
        logic        esc;
        logic [11:0] row;
        logic [11:0] col;
    } pixel_t;

    // Directed rows; typed rows carry their expected word in the row instead of a computed one.
    typedef struct {
        logic [11:0] col;
        logic [11:0] row;
        bit          typed;
        pixel_t      want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // pixel_column, pixel_row
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;        // out_column, out_row, escaped, iteration_count, r, g, b

    pixel_t      pending_q[$];
    logic [31:0] window_regs[6];
    int          err_count = 0;
    int          results_seen = 0;
    bit          stim_done = 0;

    const longint log_tbl[17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312,
                                  38336, 42196, 45904, 49472, 52911, 56229, 59434,
                                  62534, 65536};

    escape_time_fractal_pixel DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Generous ceiling on the whole run.
    initial begin
        #400ms;
        $display("tb_top: errors");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        err_count++;
    endtask

    // Pixel axis mapping with truncating division and Q4.28 saturation.
    function automatic longint map_to_plane(longint lo, longint hi, longint pos,
                                            longint span);
        longint v;
        v = lo + ((hi - lo) * pos) / span;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v;
    endfunction

    // Leading-one plus table log2, result in Q.16.
    function automatic longint log2_q16(longint unsigned v, int fb);
        int p;
        longint unsigned mant;
        longint k, r;
        if (v == 0) return 0;
        p = 63;
        while (v[p] == 1'b0) p--;
        mant = (p >= 16) ? (v >> (p - 16)) : (v << (16 - p));
        k = longint'((mant >> 12) & 15);
        r = longint'(mant & 12'hFFF);
        return longint'(p - fb) * 65536 + log_tbl[k]
               + (((log_tbl[k+1] - log_tbl[k]) * r) >>> 12);
    endfunction

    function automatic logic [7:0] mix_channel(longint a, longint b, longint t);
        longint sum;
        sum = a * 65536 + (b - a) * t;
        if (sum < 0) sum = 0;
        return 8'(sum >>> 16);
    endfunction

    // Full escape-time computation of one pixel under the current window.
    function automatic pixel_t compute_pixel(logic [11:0] col, logic [11:0] row);
        pixel_t res;
        longint w, h, cx, cy, x, y, txy, l1, l2, s;
        longint unsigned ax, ay, xx, yy, m, pxy;
        int i;
        longint unsigned n, t, p3, p5, p75;
        w = longint'(window_regs[REG_WIDTH]);
        h = longint'(window_regs[REG_HEIGHT]);
        if (w == 0) w = 1;
        if (h == 0) h = 1;
        cx = map_to_plane(longint'($signed(window_regs[REG_X_LEFT])),
                          longint'($signed(window_regs[REG_X_RIGHT])), longint'(col), w);
        cy = map_to_plane(longint'($signed(window_regs[REG_Y_BOTTOM])),
                          longint'($signed(window_regs[REG_Y_TOP])), h - longint'(row), h);
        x = 0; y = 0; i = 0;
        forever begin
            ax = (x < 0) ? longint'(-x) : longint'(x);
            ay = (y < 0) ? longint'(-y) : longint'(y);
            xx = (ax * ax) >> FRAC_BITS;
            yy = (ay * ay) >> FRAC_BITS;
            m = xx + yy;
            if (m > (64'd4 << FRAC_BITS) || i >= ITER_LIMIT) break;
            pxy = (ax * ay) >> (FRAC_BITS - 1);
            txy = ((x < 0) != (y < 0)) ? -longint'(pxy) : longint'(pxy);
            x = longint'(xx) - longint'(yy) + cx;
            y = txy + cy;
            i++;
        end
        res = '0;
        res.col = col;
        res.row = row;
        res.esc = (i < ITER_LIMIT);
        res.iters = 10'(i);
        if (res.esc) begin
            l1 = log2_q16(m, FRAC_BITS);
            l2 = log2_q16((l1 < 0) ? 0 : longint'(l1), 16);
            s = longint'(i + 2) * 65536 - l2;
            if (s < 0) s = 0;
            n = s >> 16;
            t = s & 16'hFFFF;
            p3 = (3 * n) / 10;
            p5 = n >> 1;
            p75 = (3 * n) >> 2;
            res.red   = mix_channel(p3 & 255, (p75 + 1) & 255, t);
            res.green = mix_channel(p5 & 255, (p3 + 1) & 255, t);
            res.blue  = mix_channel(p75 & 255, (p5 + 1) & 255, t);
        end
        return res;
    endfunction

    // One register write, after which cfg_valid is dropped; the local window copy
    // follows the same masking.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx < 4) window_regs[idx] = val;
        else if (idx < 6) window_regs[idx] = val & 32'h1FFF;
        @(posedge aclk);
    endtask

    task automatic write_window(input logic [31:0] xr, xl, yt, yb, input logic [12:0] w, h);
        write_reg(REG_X_RIGHT, xr);
        write_reg(REG_X_LEFT, xl);
        write_reg(REG_Y_TOP, yt);
        write_reg(REG_Y_BOTTOM, yb);
        write_reg(REG_WIDTH, 32'(w));
        write_reg(REG_HEIGHT, 32'(h));
    endtask

    // Wait until every result of the phase is back, then let the unit settle.
    task automatic drain();
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Offer one pixel word after a random gap and record its prediction on acceptance.
    task automatic send_pixel(input logic [11:0] col, row, input bit typed,
                              input pixel_t want);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {row, col};
        do @(posedge aclk); while (!s_tready);
        pending_q.push_back(typed ? want : compute_pixel(col, row));
    endtask

    function automatic pixel_t black_pixel(logic [11:0] col, logic [11:0] row);
        pixel_t p;
        p = '0;
        p.col = col;
        p.row = row;
        p.iters = 10'(ITER_LIMIT);
        return p;
    endfunction

    // Stimulus: reset, directed table, then random windows and pixels.
    initial begin
        row_t dir_rows[$];
        row_t r;
        pixel_t none;
        int kind, cnt, phase_len;
        logic [11:0] c, rw;
        none = '0;
        window_regs[REG_X_RIGHT]  = 32'h1000_0000;
        window_regs[REG_X_LEFT]   = 32'hE000_0000;
        window_regs[REG_Y_TOP]    = 32'h1000_0000;
        window_regs[REG_Y_BOTTOM] = 32'hF000_0000;
        window_regs[REG_WIDTH]    = 800;
        window_regs[REG_HEIGHT]   = 600;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset window: -2 and -0.5 on the real axis are inside the set.
        dir_rows.push_back('{12'd0, 12'd300, 1, black_pixel(12'd0, 12'd300)});
        dir_rows.push_back('{12'd400, 12'd300, 1, black_pixel(12'd400, 12'd300)});
        dir_rows.push_back('{12'd0, 12'd0, 0, none});
        dir_rows.push_back('{12'd4095, 12'd4095, 0, none});
        dir_rows.push_back('{12'd0, 12'd4095, 0, none});
        dir_rows.push_back('{12'd4095, 12'd0, 0, none});
        dir_rows.push_back('{12'd799, 12'd599, 0, none});
        dir_rows.push_back('{12'd800, 12'd600, 0, none});
        dir_rows.push_back('{12'hAAA, 12'h555, 0, none});
        dir_rows.push_back('{12'h555, 12'hAAA, 0, none});
        dir_rows.push_back('{12'd600, 12'd150, 0, none});
        dir_rows.push_back('{12'd533, 12'd250, 0, none});
        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            send_pixel(r.col, r.row, r.typed, r.want);
        end
        s_tvalid <= 1'b0;
        drain();

        // Extreme window, zero height, largest width, unknown indexes ignored.
        write_window(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     13'd8191, 13'd0);
        write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_B, 32'h0000_0000);
        foreach (dir_rows[i]) send_pixel(dir_rows[i].col, dir_rows[i].row, 0, none);
        s_tvalid <= 1'b0;
        drain();
        write_window(32'h0C00_0000, 32'hE000_0000, 32'h1000_0000, 32'hF000_0000,
                     13'd0, 13'd4096);
        send_pixel(12'd0, 12'd4095, 0, none);
        send_pixel(12'd4095, 12'd2048, 0, none);
        s_tvalid <= 1'b0;
        drain();

        // Random phases.
        cnt = 0;
        while (cnt < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 3);
            case (kind)
                0: begin
                    write_window(32'h1000_0000 + $urandom_range(0, 32'h0200_0000),
                                 32'hE000_0000 - $urandom_range(0, 32'h0200_0000),
                                 32'h1000_0000 + $urandom_range(0, 32'h0200_0000),
                                 32'hF000_0000 - $urandom_range(0, 32'h0200_0000),
                                 13'($urandom_range(1, 64)), 13'($urandom_range(1, 64)));
                end
                1: begin
                    write_window($urandom, $urandom, $urandom, $urandom,
                                 13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)));
                end
                default: begin
                    write_window(32'h0800_0000 + $urandom_range(0, 32'h0800_0000),
                                 32'hE800_0000 + $urandom_range(0, 32'h0800_0000),
                                 32'h0C00_0000 + $urandom_range(0, 32'h0400_0000),
                                 32'hF000_0000 + $urandom_range(0, 32'h0400_0000),
                                 13'($urandom_range(16, 200)), 13'($urandom_range(16, 200)));
                end
            endcase
            phase_len = $urandom_range(40, 90);
            if (phase_len > RANDOM_ITEMS - cnt) phase_len = RANDOM_ITEMS - cnt;
            repeat (phase_len) begin
                if ($urandom_range(0, 4) == 0) begin
                    c  = 12'($urandom);
                    rw = 12'($urandom);
                end else begin
                    c  = 12'($urandom_range(0, window_regs[REG_WIDTH] > 4095 ? 4095 :
                                               window_regs[REG_WIDTH]));
                    rw = 12'($urandom_range(0, window_regs[REG_HEIGHT] > 4095 ? 4095 :
                                               window_regs[REG_HEIGHT]));
                end
                send_pixel(c, rw, 0, none);
                cnt++;
            end
            s_tvalid <= 1'b0;
            drain();
        end
        stim_done = 1;
    end

    // Result side: random stalls and one long hold-off to back the unit up.
    initial begin
        pixel_t got, want;
        int stall_left;
        bit held;
        stall_left = 0;
        held = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got = pixel_t'(m_tdata[58:0]);
                results_seen++;
                if (pending_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %h", m_tdata));
                end else begin
                    want = pending_q.pop_front();
                    if (got.col !== want.col)
                        report_mismatch($sformatf("column %0d, want %0d", got.col, want.col));
                    if (got.row !== want.row)
                        report_mismatch($sformatf("row %0d, want %0d", got.row, want.row));
                    if (got.esc !== want.esc)
                        report_mismatch($sformatf("escaped %0b, want %0b", got.esc, want.esc));
                    if (got.iters !== want.iters)
                        report_mismatch($sformatf("count %0d, want %0d", got.iters,
                                                  want.iters));
                    if (got.red !== want.red)
                        report_mismatch($sformatf("red %0d, want %0d", got.red, want.red));
                    if (got.green !== want.green)
                        report_mismatch($sformatf("green %0d, want %0d", got.green,
                                                  want.green));
                    if (got.blue !== want.blue)
                        report_mismatch($sformatf("blue %0d, want %0d", got.blue, want.blue));
                end
            end
            if (!held && results_seen == 30) begin
                held = 1;
                stall_left = 20000;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 9) < 7) begin
                m_tready <= 1'b1;
            end else begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                                        : $urandom_range(1, 4);
                m_tready <= 1'b0;
            end
        end
    end

    // End of run.
    initial begin
        wait (stim_done);
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (5000) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
